[sv/jsu_pkg.sv]
// shared types and constants for the json string unescaper
// no dependencies; compiled first
package jsu_pkg;

   localparam int BurstMax = 4;

   // result status codes
   localparam logic [3:0] ST_DATA    = 4'd0;
   localparam logic [3:0] ST_DONE    = 4'd1;
   localparam logic [3:0] ST_NOQUOTE = 4'd2;
   localparam logic [3:0] ST_ENDESC  = 4'd3;
   localparam logic [3:0] ST_BADHEX  = 4'd4;
   localparam logic [3:0] ST_BADPAIR = 4'd5;
   localparam logic [3:0] ST_LONEHI  = 4'd6;
   localparam logic [3:0] ST_LONELO  = 4'd7;
   localparam logic [3:0] ST_BADESC  = 4'd8;
   localparam logic [3:0] ST_CTRL    = 4'd9;
   localparam logic [3:0] ST_UNTERM  = 4'd10;

   // characters of interest
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_U     = 8'h75;

   // results caused by one request: up to four bytes, or one status result
   typedef struct packed {
      logic [BurstMax-1:0][7:0] data;
      logic [2:0]               count;
      logic [3:0]               status;
   } burst_type;

endpackage

[sv/jsu_ifs.sv]
// request and response channel interfaces
// depends on nothing; field widths fixed by the byte stream format
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       text_end;
   modport source (output valid, output in_byte, output text_end, input ready);
   modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [3:0] status;
   logic       last_of_run;
   modport source (output valid, output out_byte, output byte_valid, output status,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input status,
                   input last_of_run, output ready);
endinterface

[sv/json_string_unescape_utf8.sv]
// latency: first result of a request is presented the cycle after it is accepted
// throughput: one request per cycle while each yields at most one result and the
//   response port is ready; a multibyte escape holds the result register until drained
// rate set by the single result register feeding the response port
// reset: synchronous, clears the result register and returns to waiting for a quote
module json_string_unescape_utf8 import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);

   // request accepted this cycle
   logic      take;
   // results decoded from the current request byte
   burst_type burst;
   // result register can be reloaded
   logic      load_ok;

   assign req_chan.ready = load_ok;
   assign take           = req_chan.valid && req_chan.ready;

   // decode state machine: string mode, escape and hex unit assembly
   jsu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .in_byte  (req_chan.in_byte),
      .text_end (req_chan.text_end),
      .burst    (burst)
   );

   // result register and serializer for up to four bytes per request
   jsu_burst u_burst (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .burst    (burst),
      .load_ok  (load_ok),
      .rsp_chan (rsp_chan)
   );

   // a request never overwrites results that are still owed
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      take |-> (!rsp_chan.valid || (rsp_chan.ready && rsp_chan.last_of_run)))
      else $error("request accepted over pending results");

   // a run that is not finished keeps the response channel busy
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run) |=> rsp_chan.valid)
      else $error("result run broken off");

   // completion and error results stand alone
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ST_DATA) |->
         (rsp_chan.last_of_run && !rsp_chan.byte_valid))
      else $error("status result not alone in its run");

   // a held burst with no response taken leaves ready low
   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request ready while results are stalled");

endmodule

[sv/jsu_decode.sv]
// string decoder state machine and utf-8 encoder
// depends on jsu_pkg
module jsu_decode import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] in_byte,
   input  logic       text_end,
   output burst_type  burst
);

   typedef enum logic [2:0] {
      M_WAIT, M_STR, M_ESC, M_HEX1, M_NEED_BS, M_NEED_U, M_HEX2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] second_ff, second_in;
   logic [1:0]  hcnt_ff, hcnt_in;

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [20:0] cp;
   logic        do_utf8;
   burst_type   utf8;

   // hex digit recognition, either case
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte inside {[8'h30:8'h39]}) begin
         hex_val = 4'(in_byte - 8'h30);
      end else if (in_byte inside {[8'h61:8'h66]}) begin
         hex_val = 4'(in_byte - 8'h57);
      end else if (in_byte inside {[8'h41:8'h46]}) begin
         hex_val = 4'(in_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
      if (text_end) hex_ok = 1'b0;
   end

   // utf-8 encoding of the code point
   always_comb begin
      utf8        = '0;
      utf8.status = ST_DATA;
      if (cp < 21'h80) begin
         utf8.count   = 3'd1;
         utf8.data[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         utf8.count   = 3'd2;
         utf8.data[0] = {3'b110, cp[10:6]};
         utf8.data[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         utf8.count   = 3'd3;
         utf8.data[0] = {4'b1110, cp[15:12]};
         utf8.data[1] = {2'b10, cp[11:6]};
         utf8.data[2] = {2'b10, cp[5:0]};
      end else begin
         utf8.count   = 3'd4;
         utf8.data[0] = {5'b11110, cp[20:18]};
         utf8.data[1] = {2'b10, cp[17:12]};
         utf8.data[2] = {2'b10, cp[11:6]};
         utf8.data[3] = {2'b10, cp[5:0]};
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      first_in  = first_ff;
      second_in = second_ff;
      hcnt_in   = hcnt_ff;
      do_utf8   = 1'b0;
      cp        = 21'(first_in);
      burst     = '0;
      case (mode_ff)
         M_WAIT: begin
            if (text_end || in_byte != CH_QUOTE) begin
               burst.count  = 3'd1;
               burst.status = ST_NOQUOTE;
            end else begin
               mode_in = M_STR;
            end
         end
         M_STR: begin
            if (text_end) begin
               mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_UNTERM;
            end else if (in_byte == CH_QUOTE) begin
               mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_DONE;
            end else if (in_byte == CH_BSL) begin
               mode_in = M_ESC;
            end else if (in_byte < 8'h20) begin
               mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_CTRL;
            end else begin
               burst.count   = 3'd1;
               burst.data[0] = in_byte;
            end
         end
         M_ESC: begin
            mode_in       = M_STR;
            burst.count   = 3'd1;
            burst.data[0] = in_byte;
            if (text_end) begin
               mode_in = M_WAIT; burst.data[0] = 8'h00; burst.status = ST_ENDESC;
            end else begin
               case (in_byte)
                  CH_QUOTE, CH_BSL, CH_SLASH: ;
                  8'h62: burst.data[0] = 8'h08;
                  8'h66: burst.data[0] = 8'h0C;
                  8'h6E: burst.data[0] = 8'h0A;
                  8'h72: burst.data[0] = 8'h0D;
                  8'h74: burst.data[0] = 8'h09;
                  CH_U: begin
                     mode_in     = M_HEX1;
                     first_in    = 16'h0000;
                     hcnt_in     = 2'd0;
                     burst.count = 3'd0;
                  end
                  default: begin
                     mode_in       = M_WAIT;
                     burst.data[0] = 8'h00;
                     burst.status  = ST_BADESC;
                  end
               endcase
            end
         end
         M_HEX1: begin
            if (!hex_ok) begin
               mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_BADHEX;
            end else begin
               first_in = {first_ff[11:0], hex_val};
               hcnt_in  = hcnt_ff + 2'd1;
               // code point is the completed unit, including this digit
               cp       = 21'(first_in);
               if (hcnt_ff == 2'd3) begin
                  if (first_in inside {[16'hD800:16'hDBFF]}) begin
                     mode_in = M_NEED_BS;
                  end else if (first_in inside {[16'hDC00:16'hDFFF]}) begin
                     mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_LONELO;
                  end else begin
                     mode_in = M_STR;
                     do_utf8 = 1'b1;
                  end
               end
            end
         end
         M_NEED_BS: begin
            if (text_end || in_byte != CH_BSL) begin
               mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_LONEHI;
            end else begin
               mode_in = M_NEED_U;
            end
         end
         M_NEED_U: begin
            if (text_end || in_byte != CH_U) begin
               mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_LONEHI;
            end else begin
               mode_in   = M_HEX2;
               second_in = 16'h0000;
               hcnt_in   = 2'd0;
            end
         end
         M_HEX2: begin
            if (!hex_ok) begin
               mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_BADPAIR;
            end else begin
               second_in = {second_ff[11:0], hex_val};
               hcnt_in   = hcnt_ff + 2'd1;
               // surrogate pair: 0x10000 plus ten bits from each unit
               cp        = 21'h10000 + {1'b0, first_ff[9:0], second_in[9:0]};
               if (hcnt_ff == 2'd3) begin
                  if (second_in inside {[16'hDC00:16'hDFFF]}) begin
                     mode_in = M_STR;
                     do_utf8 = 1'b1;
                  end else begin
                     mode_in = M_WAIT; burst.count = 3'd1; burst.status = ST_BADPAIR;
                  end
               end
            end
         end
         default: mode_in = M_WAIT;
      endcase
      if (do_utf8) burst = utf8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_WAIT;
         first_ff  <= '0;
         second_ff <= '0;
         hcnt_ff   <= '0;
      end else if (take) begin
         mode_ff   <= mode_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         hcnt_ff   <= hcnt_in;
      end
   end

endmodule

[sv/jsu_burst.sv]
// result register that plays out the results of one request, one per cycle while the response channel is ready
// depends on jsu_pkg and jsu_rsp_if
module jsu_burst import jsu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      take,
   input  burst_type burst,
   output logic      load_ok,
   jsu_rsp_if.source rsp_chan
);

   logic [BurstMax-1:0][7:0] data_ff;
   logic [2:0]               count_ff;
   logic [3:0]               status_ff;
   logic [1:0]               idx_ff;
   logic                     last;
   logic                     pop;

   assign last    = (3'({1'b0, idx_ff}) + 3'd1) == count_ff;
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   // take a new request once the held results are gone or the final one leaves now
   assign load_ok = (count_ff == 3'd0) || (pop && last);

   assign rsp_chan.valid       = count_ff != 3'd0;
   assign rsp_chan.out_byte    = data_ff[idx_ff];
   assign rsp_chan.byte_valid  = status_ff == ST_DATA;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.last_of_run = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (take) begin
         data_ff   <= burst.data;
         count_ff  <= burst.count;
         status_ff <= burst.status;
         idx_ff    <= '0;
      end else if (pop) begin
         if (last) count_ff <= '0;
         else idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule
